@@ rtl/assert_macros.svh @@
// Assertion macros shared by the sequencer RTL files.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define SSS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sequencer assertion failed");

// Checks that the consequent holds in the cycle after the trigger.
`define SSS_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("sequencer assertion failed");

`endif

@@ rtl/sss_pkg.sv @@
// Shared types and constants of the sample slice step sequencer.
// No dependencies.
`timescale 1ns / 1ps

package sss_pkg;

  localparam int unsigned PadW      = 4;
  localparam int unsigned Pads      = 16;
  localparam int unsigned PosW      = 13;
  localparam int unsigned SlotW     = 5;
  localparam int unsigned GainW     = 7;
  localparam int unsigned DeltaW    = 8;
  localparam logic [PosW-1:0] FullScale = 13'd4096;

  // Input item kinds.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PAD    = 2'd1,
    OP_RECORD = 2'd2,
    OP_ENCODE = 2'd3
  } op_e;

  // Held key modes.
  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_SOUND   = 2'd1;
  localparam logic [1:0] MODE_PATTERN = 2'd2;
  localparam logic [1:0] MODE_BOTH    = 2'd3;

  typedef struct packed {
    logic [PosW-1:0] start;
    logic [PosW-1:0] length;
  } slice_t;

  typedef struct packed {
    logic             re;
    logic             we;
    logic [PadW-1:0]  addr;
    logic [SlotW-1:0] wdata;
  } pat_req_t;

  typedef struct packed {
    logic            re;
    logic            we;
    logic [PadW-1:0] addr;
    slice_t          wdata;
  } sl_req_t;

endpackage

@@ rtl/sss_pattern_mem.sv @@
// Pattern memory: one slot per step, 0 for empty, k for pad k-1.
// Depends on sss_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sss_pattern_mem
  import sss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pat_req_t         req_i,
  output logic [SlotW-1:0] rdata_o,
  output logic [Pads-1:0]  filled_o
);

  logic [SlotW-1:0] mem [Pads];
  logic [SlotW-1:0] rd_q;
  logic [PadW-1:0]  ra_q;
  logic [Pads-1:0]  filled_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.addr];
      ra_q <= req_i.addr;
    end
  end

  // A filled bit per step stands for a nonzero slot, so reset needs no sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else if (req_i.we) begin
      filled_q[req_i.addr] <= (req_i.wdata != '0);
    end
  end

  assign rdata_o  = filled_q[ra_q] ? rd_q : '0;
  assign filled_o = filled_q;

  `SSS_ASSERT(a_pat_no_rw_overlap, clk_i, rst_ni, !(req_i.we && req_i.re))

endmodule

@@ rtl/sss_slice_mem.sv @@
// Slice memory: start and length of each pad's slice, Q1.12.
// Depends on sss_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sss_slice_mem
  import sss_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  sl_req_t req_i,
  output slice_t  rdata_o
);

  slice_t          mem [Pads];
  slice_t          rd_q;
  logic [PadW-1:0] ra_q;
  logic [Pads-1:0] vld_q;
  slice_t          rst_val;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.addr];
      ra_q <= req_i.addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.addr] <= 1'b1;
    end
  end

  // Untouched entries read as their reset slice: pad i starts at i/16.
  always_comb begin
    rst_val.start  = {1'b0, ra_q, 8'd0};
    rst_val.length = FullScale >> 4;
  end

  assign rdata_o = vld_q[ra_q] ? rd_q : rst_val;

  `SSS_ASSERT(a_sl_no_rw_overlap, clk_i, rst_ni, !(req_i.we && req_i.re))

endmodule

@@ rtl/sss_nudge.sv @@
// Encoder nudge: adds gain times delta to a position and clamps to 0..1.0.
// Depends on sss_pkg.
`timescale 1ns / 1ps

module sss_nudge
  import sss_pkg::*;
(
  input  logic [PosW-1:0]          cur_i,
  input  logic [GainW-1:0]         gain_i,
  input  logic signed [DeltaW-1:0] delta_i,
  output logic [PosW-1:0]          pos_o
);

  logic signed [15:0] prod;
  logic signed [16:0] sum;

  always_comb begin
    prod = $signed({9'd0, gain_i}) * $signed({{8{delta_i[DeltaW-1]}}, delta_i});
    sum  = $signed({prod[15], prod}) + $signed({4'd0, cur_i});
    if (sum[16]) begin
      pos_o = '0;
    end else if (sum > $signed({4'd0, FullScale})) begin
      pos_o = FullScale;
    end else begin
      pos_o = sum[PosW-1:0];
    end
  end

endmodule

@@ rtl/sample_slice_step_sequencer.sv @@
// Top level of the sample slice step sequencer: control sequencer and output register.
// Depends on sss_pkg, sss_pattern_mem, sss_slice_mem, sss_nudge, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The sequencer takes one event item at a time: a step tick, a pad press, a
// record toggle or an encoder move. Its pattern and slice tables live in two
// small synchronous memories that are read in the accept cycle and written
// back in the following cycle. An item passes from accept through evaluate
// and write back to result load; a tick whose step holds a slice also passes
// through a play step, since the slice memory is read a second time at the
// address that the pattern slot gives. The next item is accepted as soon as
// the result sits in the output register, even while it waits to be taken;
// only a result that finds the output register still full waits. Each item
// yields exactly one result item carrying the lights and status after the
// update. Reset needs no clearing pass: per-entry valid bits stand in for the
// reset contents of both memories. The user must write the encoder gain through
// cfg_we_i / cfg_wdata_i only while the block is idle; the block does not enforce it.
module sample_slice_step_sequencer
  import sss_pkg::*;
#(
  parameter int unsigned STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration: encoder gain.
  input  logic             cfg_we_i,
  input  logic [GainW-1:0] cfg_wdata_i,
  // Input items.
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: pad [3:0], held_mode [5:4], start_delta [13:6],
  // length_delta [21:14], zero [23:22].
  input  logic [23:0]      s_axis_tdata_i,
  // tuser: op [1:0].
  input  logic [1:0]       s_axis_tuser_i,
  // Result items.
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // tdata: slice_start [12:0], slice_length [25:13], led_mask [41:26],
  // record_on [42], step_now [46:43], zero [47].
  output logic [47:0]      m_axis_tdata_o,
  // tuser: trigger [0].
  output logic [0:0]       m_axis_tuser_o
);

  localparam int unsigned StepW = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_PLAY = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Architectural state held in flip-flops.
  logic [GainW-1:0] gain_q;
  logic [StepW-1:0] step_q;
  logic [PadW-1:0]  last_pad_q;
  logic             rec_q;
  logic [PadW-1:0]  chan_q;

  // The accepted item.
  op_e                     op_q;
  logic [PadW-1:0]         pad_q;
  logic [1:0]              mode_q;
  logic signed [DeltaW-1:0] sd_q;
  logic signed [DeltaW-1:0] ld_q;

  // Result payload gathered while the item is worked on.
  logic            trig_q;
  slice_t          play_q;

  // Output register.
  logic            out_vld_q;
  logic [47:0]     out_data_q;
  logic            out_trig_q;

  logic             accept;
  logic [StepW-1:0] step_nxt;
  logic [StepW+3:0] step_nxt_ext;
  logic [StepW+3:0] step_cur_ext;
  logic             sound;
  logic [SlotW-1:0] slot_new;

  pat_req_t         pat_req;
  sl_req_t          sl_req;
  logic [SlotW-1:0] pat_rdata;
  logic [Pads-1:0]  filled;
  slice_t           sl_rdata;
  logic [PosW-1:0]  start_new;
  logic [PosW-1:0]  length_new;
  logic [Pads-1:0]  leds;
  logic             out_free;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Step wraps at STEPS; the pattern memory is indexed by its low four bits.
  assign step_nxt     = (step_q == StepW'(STEPS - 1)) ? '0 : step_q + 1'b1;
  assign step_nxt_ext = {4'd0, step_nxt};
  assign step_cur_ext = {4'd0, step_q};

  assign sound    = (mode_q == MODE_SOUND) || (mode_q == MODE_BOTH);
  assign slot_new = {1'b0, last_pad_q} + 1'b1;
  assign out_free = !out_vld_q || m_axis_tready_i;

  sss_pattern_mem u_pat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (pat_req),
    .rdata_o  (pat_rdata),
    .filled_o (filled)
  );

  sss_slice_mem u_slice (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sl_req),
    .rdata_o (sl_rdata)
  );

  sss_nudge u_nudge_start (
    .cur_i   (sl_rdata.start),
    .gain_i  (gain_q),
    .delta_i (sd_q),
    .pos_o   (start_new)
  );

  sss_nudge u_nudge_length (
    .cur_i   (sl_rdata.length),
    .gain_i  (gain_q),
    .delta_i (ld_q),
    .pos_o   (length_new)
  );

  // Memory requests. Reads go out in the accept cycle, write-backs while the
  // read data is evaluated, and a playing tick reads the slice memory again.
  always_comb begin
    pat_req              = '0;
    sl_req               = '0;
    state_d              = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pat_req.re = 1'b1;
          pat_req.addr = (op_e'(s_axis_tuser_i) == OP_TICK) ? step_nxt_ext[3:0]
                                                            : s_axis_tdata_i[3:0];
          sl_req.re   = 1'b1;
          sl_req.addr = (op_e'(s_axis_tuser_i) == OP_ENCODE) ? last_pad_q
                                                             : s_axis_tdata_i[3:0];
          state_d     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_DONE;
        case (op_q)
          OP_TICK: begin
            if (pat_rdata != '0) begin
              sl_req.re   = 1'b1;
              sl_req.addr = pat_rdata[PadW-1:0] - 1'b1;
              state_d     = ST_PLAY;
            end
          end
          OP_PAD: begin
            if (!sound && (mode_q == MODE_NONE) && rec_q) begin
              pat_req.we    = 1'b1;
              pat_req.addr  = pad_q;
              pat_req.wdata = (pat_rdata == slot_new) ? '0 : slot_new;
            end
          end
          OP_ENCODE: begin
            sl_req.we           = 1'b1;
            sl_req.addr         = last_pad_q;
            sl_req.wdata.start  = start_new;
            sl_req.wdata.length = length_new;
          end
          default: begin
          end
        endcase
      end
      ST_PLAY: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Lights after the update: the chosen channel while the sound key is held,
  // otherwise the current step together with every filled step.
  always_comb begin
    if (sound) begin
      leds = Pads'(1) << chan_q;
    end else begin
      leds = (Pads'(1) << step_cur_ext[3:0]) | filled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      gain_q     <= GainW'(4);
      step_q     <= '0;
      last_pad_q <= '0;
      rec_q      <= 1'b0;
      chan_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (state_q == ST_EVAL) begin
        case (op_q)
          OP_TICK: begin
            step_q <= step_nxt;
          end
          OP_PAD: begin
            if (sound) begin
              chan_q <= pad_q;
            end else if ((mode_q == MODE_NONE) && !rec_q) begin
              last_pad_q <= pad_q;
            end
          end
          OP_RECORD: begin
            rec_q <= !rec_q;
          end
          default: begin
          end
        endcase
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Item and payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(s_axis_tuser_i);
      pad_q  <= s_axis_tdata_i[3:0];
      mode_q <= s_axis_tdata_i[5:4];
      sd_q   <= s_axis_tdata_i[13:6];
      ld_q   <= s_axis_tdata_i[21:14];
    end
    if (state_q == ST_EVAL) begin
      // Only a pad press in normal mode with record off plays here.
      if ((op_q == OP_PAD) && !sound && (mode_q == MODE_NONE) && !rec_q) begin
        trig_q <= 1'b1;
        play_q <= sl_rdata;
      end else begin
        trig_q <= 1'b0;
        play_q <= '0;
      end
    end
    if (state_q == ST_PLAY) begin
      trig_q <= 1'b1;
      play_q <= sl_rdata;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_trig_q <= trig_q;
      out_data_q <= {1'b0, step_cur_ext[3:0], rec_q, leds, play_q.length, play_q.start};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_trig_q;

  `SSS_ASSERT_NEXT(a_accept_to_eval, clk_i, rst_ni, accept, state_q == ST_EVAL)
  `SSS_ASSERT(a_play_after_eval, clk_i, rst_ni,
    (state_q != ST_PLAY) || ($past(state_q) == ST_EVAL))
  `SSS_ASSERT(a_no_trig_zero_slice, clk_i, rst_ni,
    !(m_axis_tvalid_o && !m_axis_tuser_o[0]) || (m_axis_tdata_o[25:0] == 26'd0))

endmodule
